// ===== sv/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// shared types and constants of the first-fit free extent allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int UNIT_BITS   = 20;
    localparam int SIZE_W      = UNIT_BITS + 1;
    localparam int SUM_W       = SIZE_W + 1;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int EXT_W       = UNIT_BITS + SIZE_W;

    localparam logic [SIZE_W-1:0] POOL_RESET = SIZE_W'(200000);
    localparam logic [SIZE_W-1:0] UNIT_SPAN  = SIZE_W'(1) << UNIT_BITS;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [UNIT_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
    } t_ext;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_ext              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== sv/ffa_req_if.sv =====
// ----------------------------------------------------------------------------
// ffa_req_if
// request channel: allocate or free one extent
// ----------------------------------------------------------------------------
`default_nettype none

interface ffa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [ffa_pkg::UNIT_BITS-1:0] offset;
    logic [ffa_pkg::SIZE_W-1:0]    length;

    modport source (output valid, kind, offset, length, input ready);
    modport sink   (input valid, kind, offset, length, output ready);
endinterface

`default_nettype wire

// ===== sv/ffa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffa_rsp_if
// response channel: status, allocated offset and free extent count
// ----------------------------------------------------------------------------
`default_nettype none

interface ffa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [ffa_pkg::UNIT_BITS-1:0] offset_res;
    logic [ffa_pkg::CNT_W-1:0]     free_extents;

    modport source (output valid, status, offset_res, free_extents, input ready);
    modport sink   (input valid, status, offset_res, free_extents, output ready);
endinterface

`default_nettype wire

// ===== sv/first_fit_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// first-fit extent allocator with coalescing of freed extents
// ----------------------------------------------------------------------------
// usage
//   i_req carries one item: kind 0 allocates length units, kind 1 frees the
//   extent (offset, length). every item gives exactly one item on o_rsp:
//   status, the allocated offset and the number of free extents left.
//   i_cfg_we / i_cfg_data set the pool size and rebuild the table as one
//   extent starting at unit 0; write only while the block is idle.
// timing
//   the free extent table lives in a two-bank ram. every item streams the
//   current bank into the other one, one entry per cycle, then the banks
//   swap on success. the table holds at most 32 free extents, and the
//   next item can be accepted as soon as the result is loaded. one item
//   is in work at a time; i_req.ready is high only when idle.
// reset and stall
//   synchronous reset loads a pool of 200000 units as one extent. a result
//   waits in the output register while o_rsp.ready is low; the block can
//   take the next item meanwhile, and holds a finished item until the
//   output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_free_list_allocator_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ffa_req_if.sink                         i_req,
    ffa_rsp_if.source                       o_rsp,
    input  wire logic                       i_cfg_we,
    input  wire logic [ffa_pkg::SIZE_W-1:0] i_cfg_data
);

    ffa_pkg::t_mem_req                 mem_req;
    logic [ffa_pkg::EXT_W-1:0]         rdata_raw;
    ffa_pkg::t_ext                     rdata;
    logic                              seq_idle;
    logic                              seq_done;
    logic                              res_free;
    logic [1:0]                        seq_status;
    logic [ffa_pkg::UNIT_BITS-1:0]     seq_where;
    logic [ffa_pkg::CNT_W-1:0]         seq_count;
    logic                              accept;

    // output register
    logic                              r_valid;
    logic [1:0]                        r_status;
    logic [ffa_pkg::UNIT_BITS-1:0]     r_offset;
    logic [ffa_pkg::CNT_W-1:0]         r_extents;

    assign i_req.ready = seq_idle;
    assign accept      = i_req.valid && seq_idle;
    assign res_free    = !r_valid || o_rsp.ready;
    assign rdata       = ffa_pkg::t_ext'(rdata_raw);

    // extent table, bank bit on top of the entry index
    ffa_ram #(
        .ADDR_W (ffa_pkg::ADDR_W),
        .DATA_W (ffa_pkg::EXT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata_raw)
    );

    ffa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_kind     (i_req.kind),
        .i_off      (i_req.offset),
        .i_len      (i_req.length),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_mem      (mem_req),
        .i_rdata    (rdata),
        .i_res_free (res_free),
        .o_idle     (seq_idle),
        .o_done     (seq_done),
        .o_status   (seq_status),
        .o_where    (seq_where),
        .o_count    (seq_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (seq_done) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload only loads when a result completes
    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_status  <= seq_status;
            r_offset  <= seq_where;
            r_extents <= seq_count;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.offset_res   = r_offset;
    assign o_rsp.free_extents = r_extents;

endmodule

`default_nettype wire

// ===== sv/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 41
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/ffa_seq.sv =====
// ----------------------------------------------------------------------------
// ffa_seq
// table sequencer: streams the extent table from one bank into the other
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic                          i_kind,
    input  wire logic [ffa_pkg::UNIT_BITS-1:0] i_off,
    input  wire logic [ffa_pkg::SIZE_W-1:0]    i_len,
    input  wire logic                          i_cfg_we,
    input  wire logic [ffa_pkg::SIZE_W-1:0]    i_cfg_data,
    output ffa_pkg::t_mem_req                  o_mem,
    input  wire ffa_pkg::t_ext                 i_rdata,
    input  wire logic                          i_res_free,
    output logic                               o_idle,
    output logic                               o_done,
    output logic [1:0]                         o_status,
    output logic [ffa_pkg::UNIT_BITS-1:0]      o_where,
    output logic [ffa_pkg::CNT_W-1:0]          o_count
);

    localparam int UB = ffa_pkg::UNIT_BITS;
    localparam int SW = ffa_pkg::SIZE_W;
    localparam int CW = ffa_pkg::CNT_W;
    localparam int IW = ffa_pkg::IDX_W;
    localparam int PW = ffa_pkg::SUM_W - ffa_pkg::UNIT_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(ffa_pkg::TABLE_DEPTH);

    ffa_pkg::t_state        r_state, n_state;
    logic                   r_bank, n_bank;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_kind;
    logic [UB-1:0]          r_off;
    logic [SW-1:0]          r_len;
    logic [CW-1:0]          r_ptr, n_ptr;
    logic [CW-1:0]          r_wptr, n_wptr;
    logic                   r_ins, n_ins;
    logic                   r_have, n_have;
    ffa_pkg::t_ext          r_cur, n_cur;
    logic                   r_found, n_found;
    logic [UB-1:0]          r_where, n_where;

    ffa_pkg::t_ext          el;
    ffa_pkg::t_ext          emit_data;
    logic                   emit;
    logic                   at_end;
    logic [ffa_pkg::SUM_W-1:0] cur_end;
    logic [ffa_pkg::SUM_W-1:0] sum;
    logic [SW-1:0]          pool;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffa_pkg::S_IDLE;
            r_bank  <= 1'b0;
            r_count <= CW'(1);
            r_ptr   <= '0;
            r_wptr  <= '0;
            r_ins   <= 1'b0;
            r_have  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_count <= n_count;
            r_ptr   <= n_ptr;
            r_wptr  <= n_wptr;
            r_ins   <= n_ins;
            r_have  <= n_have;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kind <= i_kind;
            r_off  <= i_off;
            r_len  <= i_len;
        end
        r_cur   <= n_cur;
        r_where <= n_where;
    end

    always_comb begin
        n_state  = r_state;
        n_bank   = r_bank;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_wptr   = r_wptr;
        n_ins    = r_ins;
        n_have   = r_have;
        n_cur    = r_cur;
        n_found  = r_found;
        n_where  = r_where;
        el       = i_rdata;
        emit     = 1'b0;
        emit_data = r_cur;
        at_end   = (r_ptr == r_count);
        cur_end  = {PW'(0), r_cur.start} + {1'b0, r_cur.size};
        sum      = {1'b0, r_cur.size} + {1'b0, i_rdata.size};
        pool     = (i_cfg_data > ffa_pkg::UNIT_SPAN) ? ffa_pkg::UNIT_SPAN : i_cfg_data;
        o_idle   = (r_state == ffa_pkg::S_IDLE);
        o_done   = 1'b0;
        o_status = ffa_pkg::ST_OK;
        o_where  = '0;
        o_count  = r_count;
        o_mem    = '0;
        o_mem.raddr = {r_bank, IW'(0)};

        case (r_state)
            ffa_pkg::S_IDLE: begin
                if (i_cfg_we) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = {r_bank, IW'(0)};
                    o_mem.wdata = '{start: '0, size: pool};
                    n_count     = (pool == '0) ? '0 : CW'(1);
                end
                if (i_start) begin
                    n_state = ffa_pkg::S_SCAN;
                    n_ptr   = '0;
                    n_wptr  = '0;
                    n_ins   = 1'b0;
                    n_have  = 1'b0;
                    n_found = 1'b0;
                    n_where = '0;
                end
            end
            ffa_pkg::S_SCAN: begin
                if (r_kind == ffa_pkg::KIND_FREE) begin
                    if (!r_ins && (at_end || i_rdata.start > r_off)) begin
                        el    = '{start: r_off, size: r_len};
                        n_ins = 1'b1;
                    end else if (!at_end) begin
                        n_ptr = r_ptr + CW'(1);
                    end
                    if (at_end && r_ins) begin
                        // drain the merge accumulator
                        emit    = r_have;
                        n_state = ffa_pkg::S_DONE;
                    end else begin
                        sum = {1'b0, r_cur.size} + {1'b0, el.size};
                        if (!r_have) begin
                            n_cur  = el;
                            n_have = 1'b1;
                        end else if (cur_end == {PW'(0), el.start}) begin
                            n_cur.size = sum[SW] ? '1 : sum[SW-1:0];
                        end else begin
                            emit  = 1'b1;
                            n_cur = el;
                        end
                    end
                end else begin
                    if (at_end) begin
                        n_state = ffa_pkg::S_DONE;
                    end else begin
                        n_ptr = r_ptr + CW'(1);
                        emit_data = i_rdata;
                        emit      = 1'b1;
                        if (!r_found && r_len != '0 && i_rdata.size >= r_len) begin
                            n_found = 1'b1;
                            n_where = i_rdata.start;
                            // exact fit drops the extent, otherwise it shrinks
                            emit    = (i_rdata.size != r_len);
                            emit_data.start = i_rdata.start + r_len[UB-1:0];
                            emit_data.size  = i_rdata.size - r_len;
                        end
                    end
                end
                if (emit) begin
                    n_wptr = r_wptr + CW'(1);
                    if (r_wptr < DEPTH_C) begin
                        o_mem.we    = 1'b1;
                        o_mem.waddr = {~r_bank, r_wptr[IW-1:0]};
                        o_mem.wdata = emit_data;
                    end
                end
                o_mem.raddr = {r_bank, n_ptr[IW-1:0]};
            end
            ffa_pkg::S_DONE: begin
                if (r_kind == ffa_pkg::KIND_FREE) begin
                    if (r_len == '0) begin
                        o_status = ffa_pkg::ST_OK;
                    end else if (r_wptr > DEPTH_C) begin
                        o_status = ffa_pkg::ST_FULL;
                    end else begin
                        o_status = ffa_pkg::ST_OK;
                        o_count  = r_wptr;
                    end
                end else begin
                    if (r_found) begin
                        o_status = ffa_pkg::ST_OK;
                        o_where  = r_where;
                        o_count  = r_wptr;
                    end else begin
                        o_status = ffa_pkg::ST_NO_FIT;
                    end
                end
                if (i_res_free) begin
                    o_done  = 1'b1;
                    n_state = ffa_pkg::S_IDLE;
                    if (o_count != r_count || o_status == ffa_pkg::ST_OK) begin
                        if (!(r_kind == ffa_pkg::KIND_FREE && r_len == '0)) begin
                            n_bank = (o_status == ffa_pkg::ST_OK) ? ~r_bank : r_bank;
                        end
                    end
                    n_count = o_count;
                end
            end
            default: begin
                n_state = ffa_pkg::S_IDLE;
            end
        endcase

        if (!i_rst_n) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = '0;
            o_mem.wdata = '{start: '0, size: ffa_pkg::POOL_RESET};
        end
    end

    a_wptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wptr <= DEPTH_C + CW'(1))
        else $error("write pointer ran past the spare entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("extent count above table depth");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffa_pkg::S_IDLE && !i_cfg_we) |-> !o_mem.we)
        else $error("table written while idle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> r_state == ffa_pkg::S_IDLE)
        else $error("sequencer not idle after result");

endmodule

`default_nettype wire
